/* hw/rtl/tcphs_pkg.sv */
// ----------------------------------------------------------------------------
// tcphs_pkg
// Shared types and constants of the TCP handshake responder: transaction
// payloads, configuration register set and header constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tcphs_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_LISTEN_PORT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_ADDRESS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEER_ADDRESS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BODY_WORD_SUM = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BODY_LENGTH   = 3'd4;

   localparam logic [15:0] RST_LISTEN_PORT   = 16'd8080;
   localparam logic [31:0] RST_LOCAL_ADDRESS = 32'h7f00_0001;
   localparam logic [31:0] RST_PEER_ADDRESS  = 32'h7f00_0001;
   localparam logic [15:0] RST_BODY_WORD_SUM = 16'h0000;
   localparam logic [15:0] RST_BODY_LENGTH   = 16'd1000;

   localparam logic [7:0]  FLAG_SYN     = 8'h02;
   localparam logic [7:0]  FLAG_ACK     = 8'h10;
   localparam logic [7:0]  FLAG_SYN_ACK = 8'h12;
   localparam logic [15:0] REPLY_WINDOW = 16'd32767;
   localparam logic [7:0]  REPLY_OFFSET = 8'h50;
   localparam logic [15:0] TCP_PROTO    = 16'd6;
   localparam logic [15:0] HEADER_BYTES = 16'd20;

   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_E = 8'h45;
   localparam logic [7:0] CHAR_T = 8'h54;

   typedef struct packed {
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [31:0] seq_number;
      logic [7:0]  flag_bits;
      logic [7:0]  payload_byte0;
      logic [7:0]  payload_byte1;
      logic [7:0]  payload_byte2;
   } req_type;

   typedef struct packed {
      logic [15:0] reply_source_port;
      logic [15:0] reply_dest_port;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack;
      logic [7:0]  reply_flags;
      logic [15:0] reply_window;
      logic [7:0]  reply_offset_byte;
      logic [15:0] reply_checksum;
      logic        reply_has_body;
   } rsp_type;

   typedef struct packed {
      logic [15:0] listen_port;
      logic [31:0] local_address;
      logic [31:0] peer_address;
      logic [15:0] body_word_sum;
      logic [15:0] body_length;
   } cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/tcphs_csr.sv */
// ----------------------------------------------------------------------------
// tcphs_csr
// Configuration register file: write-only registers for port, addresses
// and response body parameters.
// ----------------------------------------------------------------------------
`default_nettype none

module tcphs_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [tcphs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tcphs_pkg::CSR_DATA_W-1:0]    csr_data,
   output tcphs_pkg::cfg_type                       cfg
);

   tcphs_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.listen_port   <= tcphs_pkg::RST_LISTEN_PORT;
         cfg_ff.local_address <= tcphs_pkg::RST_LOCAL_ADDRESS;
         cfg_ff.peer_address  <= tcphs_pkg::RST_PEER_ADDRESS;
         cfg_ff.body_word_sum <= tcphs_pkg::RST_BODY_WORD_SUM;
         cfg_ff.body_length   <= tcphs_pkg::RST_BODY_LENGTH;
      end else if (csr_write) begin
         unique case (csr_index)
            tcphs_pkg::CSR_LISTEN_PORT:   cfg_ff.listen_port   <= csr_data[15:0];
            tcphs_pkg::CSR_LOCAL_ADDRESS: cfg_ff.local_address <= csr_data[31:0];
            tcphs_pkg::CSR_PEER_ADDRESS:  cfg_ff.peer_address  <= csr_data[31:0];
            tcphs_pkg::CSR_BODY_WORD_SUM: cfg_ff.body_word_sum <= csr_data[15:0];
            tcphs_pkg::CSR_BODY_LENGTH:   cfg_ff.body_length   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/tcphs_cksum.sv */
// ----------------------------------------------------------------------------
// tcphs_cksum
// Reply checksum: one's-complement adder tree over the reply header,
// pseudo header and optional body sum, folded and complemented.
// ----------------------------------------------------------------------------
`default_nettype none

module tcphs_cksum (
   input  wire tcphs_pkg::cfg_type   cfg,
   input  wire logic [15:0]          sport,
   input  wire logic [31:0]          ack,
   input  wire logic [7:0]           flags,
   input  wire logic                 has_body,
   output logic [15:0]               checksum
);

   logic [15:0] tcp_len;
   logic [15:0] body_sum;
   logic [19:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;

   always_comb begin
      tcp_len  = tcphs_pkg::HEADER_BYTES + (has_body ? cfg.body_length : 16'd0);
      body_sum = has_body ? cfg.body_word_sum : 16'd0;
      sum = 20'(cfg.listen_port) + 20'(sport) + 20'(sport)
          + 20'(ack[31:16]) + 20'(ack[15:0])
          + 20'({tcphs_pkg::REPLY_OFFSET, flags}) + 20'(tcphs_pkg::REPLY_WINDOW)
          + 20'(cfg.local_address[31:16]) + 20'(cfg.local_address[15:0])
          + 20'(cfg.peer_address[31:16]) + 20'(cfg.peer_address[15:0])
          + 20'(tcphs_pkg::TCP_PROTO) + 20'(tcp_len) + 20'(body_sum);
      fold1    = 17'(sum[15:0]) + 17'(sum[19:16]);
      fold2    = fold1[15:0] + 16'(fold1[16]);
      checksum = ~fold2;
   end

endmodule

`default_nettype wire

/* hw/rtl/tcphs_engine.sv */
// ----------------------------------------------------------------------------
// tcphs_engine
// Segment register, handshake state machine, reply build and reply
// register with stall handling.
// ----------------------------------------------------------------------------
`default_nettype none

module tcphs_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tcphs_pkg::cfg_type   cfg,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire tcphs_pkg::req_type   req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output tcphs_pkg::rsp_type        rsp_data
);

   typedef enum logic [1:0] {
      LISTEN      = 2'd0,
      SYN_RCVD    = 2'd1,
      ESTABLISHED = 2'd2
   } state_type;

   state_type           state_ff, state_in;
   logic                seg_valid_ff;
   tcphs_pkg::req_type  seg_ff;
   logic                rsp_valid_ff;
   tcphs_pkg::rsp_type  rsp_ff, rsp_in;

   logic        req_accept;
   logic        emit;
   logic        has_body;
   logic        out_free;
   logic        seg_advance;
   logic [31:0] ack;
   logic [7:0]  flags;
   logic [15:0] checksum;
   logic        port_match;
   logic        is_get;

   always_comb begin
      port_match = seg_ff.dest_port == cfg.listen_port;
      is_get     = seg_ff.payload_byte0 == tcphs_pkg::CHAR_G
                && seg_ff.payload_byte1 == tcphs_pkg::CHAR_E
                && seg_ff.payload_byte2 == tcphs_pkg::CHAR_T;
      emit     = 1'b0;
      has_body = 1'b0;
      state_in = state_ff;
      unique case (state_ff)
         LISTEN: begin
            if ((seg_ff.flag_bits & tcphs_pkg::FLAG_SYN) != 8'h00 && port_match) begin
               emit     = 1'b1;
               state_in = SYN_RCVD;
            end
         end
         SYN_RCVD: begin
            if ((seg_ff.flag_bits & tcphs_pkg::FLAG_ACK) != 8'h00) begin
               state_in = ESTABLISHED;
            end
         end
         default: begin
            if (port_match && is_get) begin
               emit     = 1'b1;
               has_body = 1'b1;
            end
         end
      endcase
      emit = emit && seg_valid_ff;
   end

   assign ack   = seg_ff.seq_number + 32'd1;
   assign flags = has_body ? tcphs_pkg::FLAG_ACK : tcphs_pkg::FLAG_SYN_ACK;

   tcphs_cksum u_cksum (
      .cfg      (cfg),
      .sport    (seg_ff.source_port),
      .ack      (ack),
      .flags    (flags),
      .has_body (has_body),
      .checksum (checksum)
   );

   always_comb begin
      rsp_in.reply_source_port = cfg.listen_port;
      rsp_in.reply_dest_port   = seg_ff.source_port;
      rsp_in.reply_seq         = 32'(seg_ff.source_port);
      rsp_in.reply_ack         = ack;
      rsp_in.reply_flags       = flags;
      rsp_in.reply_window      = tcphs_pkg::REPLY_WINDOW;
      rsp_in.reply_offset_byte = tcphs_pkg::REPLY_OFFSET;
      rsp_in.reply_checksum    = checksum;
      rsp_in.reply_has_body    = has_body;
   end

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign seg_advance = seg_valid_ff && (out_free || !emit);
   assign req_stall   = seg_valid_ff && !seg_advance;
   assign req_accept  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LISTEN;
         seg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (seg_advance) begin
            state_ff <= state_in;
         end
         if (req_accept) begin
            seg_valid_ff <= 1'b1;
         end else if (seg_advance) begin
            seg_valid_ff <= 1'b0;
         end
         if (seg_advance && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         seg_ff <= req_data;
      end
      if (seg_advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // established is never left
   a_est_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff == ESTABLISHED |=> state_ff == ESTABLISHED)
      else $error("handshake left established state");

   // a body reply only exists once established
   a_body_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.reply_has_body |-> state_ff == ESTABLISHED)
      else $error("body reply outside established state");

   // a syn-ack reply means the listen state was left
   a_synack_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.reply_has_body |-> state_ff != LISTEN)
      else $error("syn-ack reply while still listening");

   // stall only while a segment is held
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> seg_valid_ff && emit && rsp_valid_ff)
      else $error("stall without a blocked segment");

endmodule

`default_nettype wire

/* hw/rtl/tcp_handshake_responder.sv */
// ----------------------------------------------------------------------------
// tcp_handshake_responder
// Three-way handshake responder: answers a SYN to the server port with a
// SYN|ACK header and, once established, a GET segment with an ACK header.
//
// Usage:
//   req_* carries one received segment header per transaction; rsp_* carries
//   a reply header when the segment calls for one, otherwise nothing.
//   csr_* writes the configuration registers; write them only while idle.
//   Path: segment register, then reply register, before rsp_valid rises.
//   Throughput: one segment per cycle unless req_stall holds it; the
//   checksum adder tree and the state update both fit between the segment
//   and reply registers.
//   Reset: state returns to listen, registers take their defaults, and
//   both pipeline stages are emptied.
//   Stall: rsp_stall holds the reply register; a following segment that
//   needs a reply then waits in the segment register and req_stall rises,
//   while segments that need no reply keep flowing through.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_handshake_responder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire tcphs_pkg::req_type                  req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output tcphs_pkg::rsp_type                       rsp_data,
   input  wire logic                                csr_write,
   input  wire logic [tcphs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tcphs_pkg::CSR_DATA_W-1:0]    csr_data
);

   tcphs_pkg::cfg_type cfg;

   tcphs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tcphs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
